// ===== src/servo_instruction_packet_framer_macros.svh =====
// Assertion macros for the framer's top-level RTL file.
`ifndef SERVO_INSTRUCTION_PACKET_FRAMER_MACROS_SVH
`define SERVO_INSTRUCTION_PACKET_FRAMER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SIPF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SIPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== src/sipf_pkg.sv =====
// Types, constants and the byte selector of the servo instruction packet framer.
package sipf_pkg;

  localparam logic [7:0] START_BYTE    = 8'hFF;
  localparam logic [7:0] SINGLE_LEN    = 8'h07;
  localparam logic [7:0] BROADCAST_ID  = 8'hFE;
  localparam logic [7:0] PAIR_LEN      = 8'h0E;
  localparam logic [7:0] PER_SERVO_LEN = 8'h04;
  localparam logic [9:0] POS_MAX       = 10'd1023;

  localparam int IDX_W       = 5;
  localparam int SINGLE_BYTES = 11;
  localparam int PAIR_BYTES   = 18;
  localparam logic [IDX_W-1:0] SINGLE_LAST_IDX = IDX_W'(SINGLE_BYTES - 1);
  localparam logic [IDX_W-1:0] PAIR_LAST_IDX   = IDX_W'(PAIR_BYTES - 1);
  // First byte after the two start bytes opens the checksum sum.
  localparam logic [IDX_W-1:0] SUM_FIRST_IDX   = IDX_W'(2);

  localparam int CFG_ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_WRITE_OPCODE      = 2'd0,
    REG_SYNC_WRITE_OPCODE = 2'd1,
    REG_GOAL_ADDRESS      = 2'd2,
    REG_NONE              = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] write_opcode;
    logic [7:0] sync_write_opcode;
    logic [7:0] goal_address;
  } cfg_regs_t;

  typedef struct packed {
    logic       pair;
    logic [9:0] pos;
    logic [9:0] mpos;
    logic [7:0] spd_l;
    logic [7:0] spd_h;
    logic [7:0] id1;
    logic [7:0] id2;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pop;
  } fifo_stat_t;

  typedef struct packed {
    logic             active;
    logic [IDX_W-1:0] idx;
  } back_stat_t;

  // Packet byte at position idx, start bytes included; the checksum slot reads zero.
  function automatic logic [7:0] packet_byte(cmd_t c, cfg_regs_t r, logic [IDX_W-1:0] idx);
    logic [PAIR_BYTES*8-1:0] pv;
    logic [PAIR_BYTES*8-1:0] sv;
    logic [7:0]              sel;
    pv = {8'h00, c.spd_h, c.spd_l, {6'b0, c.mpos[9:8]}, c.mpos[7:0], c.id2,
          c.spd_h, c.spd_l, {6'b0, c.pos[9:8]}, c.pos[7:0], c.id1,
          PER_SERVO_LEN, r.goal_address, r.sync_write_opcode, PAIR_LEN,
          BROADCAST_ID, START_BYTE, START_BYTE};
    sv = {{(PAIR_BYTES - SINGLE_BYTES){8'h00}}, 8'h00, c.spd_h, c.spd_l,
          {6'b0, c.pos[9:8]}, c.pos[7:0], r.goal_address, r.write_opcode,
          SINGLE_LEN, c.id1, START_BYTE, START_BYTE};
    sel = {idx, 3'b000};
    return c.pair ? pv[sel +: 8] : sv[sel +: 8];
  endfunction

endpackage

// ===== src/sipf_front.sv =====
// Input side: takes move commands, classifies the mode and precomputes the mirror position.
module sipf_front (
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [47:0]        in_tdata,   // goal_position, speed_low, speed_high, first_id, second_id
  input  logic               in_tuser,   // func
  input  sipf_pkg::fifo_stat_t q_stat,
  output logic               q_push,
  output sipf_pkg::cmd_t     q_cmd
);
  import sipf_pkg::*;

  logic [47:42] unused_pad;

  assign unused_pad = in_tdata[47:42];
  assign in_tready  = !q_stat.full;
  assign q_push     = in_tvalid && in_tready;

  always_comb begin
    q_cmd.pair  = in_tuser;
    q_cmd.pos   = in_tdata[9:0];
    q_cmd.mpos  = POS_MAX - in_tdata[9:0];
    q_cmd.spd_l = in_tdata[17:10];
    q_cmd.spd_h = in_tdata[25:18];
    q_cmd.id1   = in_tdata[33:26];
    // Single mode carries id2 along but never sends it.
    q_cmd.id2   = in_tdata[41:34];
  end

endmodule

// ===== src/sipf_fifo.sv =====
// Short command queue between the input side and the byte sequencer.
module sipf_fifo #(
  parameter int WIDTH = 53,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output sipf_pkg::fifo_stat_t stat
);
  import sipf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign do_push = push && (count_r != CNT_FULL);
  assign do_pop  = pop && (count_r != '0);
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    stat.full  = (count_r == CNT_FULL);
    stat.empty = (count_r == '0);
    stat.pop   = do_pop;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== src/sipf_back.sv =====
// Byte sequencer: walks one queued command through its packet and builds the checksum.
module sipf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sipf_pkg::cfg_regs_t  regs,
  input  sipf_pkg::cmd_t       q_cmd,
  input  sipf_pkg::fifo_stat_t q_stat,
  output logic                 q_pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // tx_byte
  output logic                 out_tlast,  // last_byte
  output sipf_pkg::back_stat_t stat
);
  import sipf_pkg::*;

  cmd_t             cmd_r, cmd_nxt;
  logic             active_r, active_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       acc_r, acc_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;
  logic             advance, is_last;
  logic [7:0]       cur_byte;

  assign advance  = !out_valid_r || out_tready;
  assign is_last  = idx_r == (cmd_r.pair ? PAIR_LAST_IDX : SINGLE_LAST_IDX);
  assign cur_byte = packet_byte(cmd_r, regs, idx_r);
  assign q_pop    = !active_r && !q_stat.empty;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    stat.active = active_r;
    stat.idx    = idx_r;
  end

  always_comb begin
    cmd_nxt       = cmd_r;
    active_nxt    = active_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (advance) begin
      out_valid_nxt = active_r;
      if (active_r) begin
        out_data_nxt = is_last ? ~acc_r : cur_byte;
        out_last_nxt = is_last;
        idx_nxt      = idx_r + 1'b1;
        if (idx_r == SUM_FIRST_IDX) begin
          acc_nxt = cur_byte;
        end else begin
          acc_nxt = acc_r + cur_byte;
        end
        if (is_last) begin
          active_nxt = 1'b0;
        end
      end
    end
    // Load the next command once the current packet's checksum byte is registered for output.
    if (q_pop) begin
      cmd_nxt    = q_cmd;
      active_nxt = 1'b1;
      idx_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// ===== src/servo_instruction_packet_framer.sv =====
// Servo instruction packet framer: one move command in, an 11-byte single write
// (func 0) or an 18-byte mirrored pair sync write (func 1) out, one byte per
// transaction with tlast on the checksum byte. The byte sequencer sends one byte
// per cycle while out_tready is high and takes the next queued command only after
// the checksum byte of the current packet is registered, never in mid-packet;
// commands arriving faster are buffered in a FIFO_DEPTH-entry queue and in_tready
// drops while it is full. Configuration registers (write opcode at 0x0, sync
// write opcode at 0x4, goal address at 0x8) are read live while bytes are sent,
// so write them only while no packet is in flight.
module servo_instruction_packet_framer #(
  parameter int FIFO_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // goal_position, speed_low, speed_high, first_id, second_id
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // tx_byte
  output logic        out_tlast,  // last_byte
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [sipf_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import sipf_pkg::*;
  `include "servo_instruction_packet_framer_macros.svh"

  cfg_regs_t  regs_r, regs_nxt;
  reg_idx_t   reg_sel;
  logic       cfg_wr;
  cmd_t       push_cmd;
  logic [$bits(cmd_t)-1:0] head_bits;
  cmd_t       head_cmd;
  logic       q_push, q_pop;
  fifo_stat_t q_stat;
  back_stat_t b_stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = reg_idx_t'(cfg_paddr[3:2]);

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_wr) begin
      case (reg_sel)
        REG_WRITE_OPCODE:      regs_nxt.write_opcode      = cfg_pwdata[7:0];
        REG_SYNC_WRITE_OPCODE: regs_nxt.sync_write_opcode = cfg_pwdata[7:0];
        REG_GOAL_ADDRESS:      regs_nxt.goal_address      = cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WRITE_OPCODE:      cfg_prdata = {24'h0, regs_r.write_opcode};
      REG_SYNC_WRITE_OPCODE: cfg_prdata = {24'h0, regs_r.sync_write_opcode};
      REG_GOAL_ADDRESS:      cfg_prdata = {24'h0, regs_r.goal_address};
      default:               cfg_prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.write_opcode      <= 8'd3;
      regs_r.sync_write_opcode <= 8'd131;
      regs_r.goal_address      <= 8'd30;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  sipf_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  sipf_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (push_cmd),
    .pop   (q_pop),
    .rdata (head_bits),
    .stat  (q_stat)
  );

  assign head_cmd = cmd_t'(head_bits);

  sipf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .regs       (regs_r),
    .q_cmd      (head_cmd),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .stat       (b_stat)
  );

  `SIPF_ASSERT_NEXT(a_push_lands, clk, rst_n, in_tvalid && in_tready, !q_stat.empty)
  `SIPF_ASSERT_NEXT(a_pop_starts_packet, clk, rst_n, q_stat.pop, b_stat.active && b_stat.idx == '0)
  `SIPF_ASSERT_NOW(a_idx_in_packet, clk, rst_n, b_stat.active, b_stat.idx <= PAIR_LAST_IDX)

endmodule
